### design/clcd_pkg.sv
// Shared types, constants and the init prefix table of the 4-bit LCD sequencer.
package clcd_pkg;

  // Command codes on the input channel
  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_CMD  = 2'd1,
    OP_DATA = 2'd2,
    OP_LINE = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FUNC_SET  = 3'd0,
    REG_DISP_CTL  = 3'd1,
    REG_ENTRY     = 3'd2,
    REG_LINE3     = 3'd3,
    REG_LINE4     = 3'd4
  } cfg_reg_t;

  // Sequencer states of the back end
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_HEAD,
    ST_BYTE
  } seq_state_t;

  // Steps of one byte write
  typedef enum logic [2:0] {
    PH_SETUP   = 3'd0,
    PH_HI_RISE = 3'd1,
    PH_HI_FALL = 3'd2,
    PH_LO_RISE = 3'd3,
    PH_LO_FALL = 3'd4
  } byte_phase_t;

  localparam int unsigned WAIT_W         = 17;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Line numbers of the go-to-line command
  localparam logic [2:0] LINE_NUM_2 = 3'd2;
  localparam logic [2:0] LINE_NUM_3 = 3'd3;
  localparam logic [2:0] LINE_NUM_4 = 3'd4;

  // Fixed controller commands
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CMD_DDRAM  = 8'h80;
  localparam logic [6:0] LINE2_ADDR = 7'h40;
  localparam logic [6:0] LINE1_ADDR = 7'h00;

  // Register reset values
  localparam logic [7:0] FUNC_SET_RST = 8'h28;
  localparam logic [7:0] DISP_CTL_RST = 8'h0C;
  localparam logic [7:0] ENTRY_RST    = 8'h06;
  localparam logic [6:0] LINE3_RST    = 7'h10;
  localparam logic [6:0] LINE4_RST    = 7'h50;

  // Hold times in microseconds
  localparam logic [WAIT_W-1:0] WAIT_STEP      = 17'd1;
  localparam logic [WAIT_W-1:0] WAIT_HEAD      = 17'd1000;
  localparam logic [WAIT_W-1:0] WAIT_POWER     = 17'd100000;
  localparam logic [WAIT_W-1:0] WAIT_5000      = 17'd5000;
  localparam logic [WAIT_W-1:0] WAIT_200       = 17'd200;
  localparam logic [WAIT_W-1:0] WAIT_100       = 17'd100;
  localparam logic [WAIT_W-1:0] WAIT_INIT_BYTE = 17'd1001;
  localparam logic [WAIT_W-1:0] WAIT_INIT_LAST = 17'd10001;

  // Last step of the init prefix and last init byte
  localparam logic [3:0] INIT_PRE_LAST  = 4'd10;
  localparam logic [1:0] INIT_BYTE_LAST = 2'd3;

  localparam logic [3:0] NIB_WAKE  = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;

  // Configuration register file contents
  typedef struct packed {
    logic [7:0] func_set;
    logic [7:0] disp_ctl;
    logic [7:0] entry_mode;
    logic [6:0] line3_addr;
    logic [6:0] line4_addr;
  } cfg_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] value;
  } cmd_t;

  // One bus event
  typedef struct packed {
    logic              rs;
    logic              en;
    logic [3:0]        nib;
    logic [WAIT_W-1:0] wait_us;
    logic              last;
  } event_t;

  // Power-up wake sequence before the function set byte
  function automatic event_t init_pre_event(input logic [3:0] step);
    event_t ev;
    ev = '0;
    unique case (step)
      4'd0:  ev = '{rs: 1'b0, en: 1'b0, nib: 4'h0,     wait_us: WAIT_POWER, last: 1'b0};
      4'd1:  ev = '{rs: 1'b0, en: 1'b0, nib: NIB_WAKE, wait_us: WAIT_STEP,  last: 1'b0};
      4'd2:  ev = '{rs: 1'b0, en: 1'b1, nib: NIB_WAKE, wait_us: WAIT_STEP,  last: 1'b0};
      4'd3:  ev = '{rs: 1'b0, en: 1'b0, nib: NIB_WAKE, wait_us: WAIT_5000,  last: 1'b0};
      4'd4:  ev = '{rs: 1'b0, en: 1'b1, nib: NIB_WAKE, wait_us: WAIT_STEP,  last: 1'b0};
      4'd5:  ev = '{rs: 1'b0, en: 1'b0, nib: NIB_WAKE, wait_us: WAIT_200,   last: 1'b0};
      4'd6:  ev = '{rs: 1'b0, en: 1'b1, nib: NIB_WAKE, wait_us: WAIT_STEP,  last: 1'b0};
      4'd7:  ev = '{rs: 1'b0, en: 1'b0, nib: NIB_WAKE, wait_us: WAIT_100,   last: 1'b0};
      4'd8:  ev = '{rs: 1'b0, en: 1'b0, nib: NIB_4BIT, wait_us: WAIT_STEP,  last: 1'b0};
      4'd9:  ev = '{rs: 1'b0, en: 1'b1, nib: NIB_4BIT, wait_us: WAIT_STEP,  last: 1'b0};
      4'd10: ev = '{rs: 1'b0, en: 1'b0, nib: NIB_4BIT, wait_us: WAIT_5000,  last: 1'b0};
      default: ev = '0;
    endcase
    return ev;
  endfunction

endpackage

### design/clcd_in_if.sv
// Command input channel: valid/ready plus command fields.
interface clcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic [2:0] line_number;

  modport source (output valid, op, data_byte, line_number, input ready);
  modport sink   (input valid, op, data_byte, line_number, output ready);
endinterface

### design/clcd_out_if.sv
// Bus event output channel: valid/ready plus event fields.
interface clcd_out_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic        enable_level;
  logic [3:0]  bus_nibble;
  logic [16:0] wait_us;
  logic        last_event;

  modport source (output valid, reg_select, enable_level, bus_nibble, wait_us, last_event,
                  input ready);
  modport sink   (input valid, reg_select, enable_level, bus_nibble, wait_us, last_event,
                  output ready);
endinterface

### design/clcd_cfg_if.sv
// Configuration write channel: valid/ready plus register index and data.
interface clcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_index;
  logic [7:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

### design/clcd_front.sv
// Front end: configuration registers and command classification into queue entries.
module clcd_front (
  input  logic              clk,
  input  logic              rst_n,
  clcd_in_if.sink           in_ch,
  clcd_cfg_if.sink          cfg_ch,
  input  logic              q_full,
  output logic              q_push,
  output clcd_pkg::cmd_t    q_cmd,
  output clcd_pkg::cfg_t    cfg
);
  import clcd_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [6:0] line_addr;

  // Register writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_FUNC_SET: cfg_nxt.func_set   = cfg_ch.data;
        REG_DISP_CTL: cfg_nxt.disp_ctl   = cfg_ch.data;
        REG_ENTRY:    cfg_nxt.entry_mode = cfg_ch.data;
        REG_LINE3:    cfg_nxt.line3_addr = cfg_ch.data[6:0];
        REG_LINE4:    cfg_nxt.line4_addr = cfg_ch.data[6:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{func_set: FUNC_SET_RST, disp_ctl: DISP_CTL_RST, entry_mode: ENTRY_RST,
                 line3_addr: LINE3_RST, line4_addr: LINE4_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  // DDRAM start address of the requested line; unknown lines go to the top
  always_comb begin
    unique case (in_ch.line_number)
      LINE_NUM_2: line_addr = LINE2_ADDR;
      LINE_NUM_3: line_addr = cfg_r.line3_addr;
      LINE_NUM_4: line_addr = cfg_r.line4_addr;
      default:    line_addr = LINE1_ADDR;
    endcase
  end

  // Classify the incoming beat
  always_comb begin
    q_cmd = '0;
    unique case (op_t'(in_ch.op))
      OP_INIT: q_cmd = '{is_init: 1'b1, rs: 1'b0, value: 8'h00};
      OP_CMD:  q_cmd = '{is_init: 1'b0, rs: 1'b0, value: in_ch.data_byte};
      OP_DATA: q_cmd = '{is_init: 1'b0, rs: 1'b1, value: in_ch.data_byte};
      OP_LINE: q_cmd = '{is_init: 1'b0, rs: 1'b0, value: CMD_DDRAM | {1'b0, line_addr}};
      default: q_cmd = '0;
    endcase
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

endmodule

### design/clcd_queue.sv
// Small command queue between front and back end.
module clcd_queue #(
  parameter int unsigned DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  clcd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output clcd_pkg::cmd_t head_cmd,
  output logic           empty
);
  import clcd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### design/clcd_back.sv
// Back end: expands queued commands into bus events, one per cycle unless the output stalls, into an output register.
module clcd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  clcd_pkg::cfg_t cfg,
  input  clcd_pkg::cmd_t head_cmd,
  input  logic           q_empty,
  output logic           q_pop,
  clcd_out_if.source     out_ch
);
  import clcd_pkg::*;

  seq_state_t  state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  byte_phase_t phase_r, phase_nxt;
  logic [1:0]  bidx_r, bidx_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [3:0]  held_nib_r, held_nib_nxt;
  logic        held_sel_r, held_sel_nxt;
  logic        out_valid_r, out_valid_nxt;
  event_t      out_ev_r, out_ev_nxt;

  event_t      ev;
  logic        adv;
  logic [7:0]  byte_val;
  logic [WAIT_W-1:0] final_wait;
  logic        byte_done;

  // Output register takes a new event when empty or being drained
  assign adv = (state_r != ST_IDLE) && (!out_valid_r || out_ch.ready);

  // Byte and closing wait of the current byte write
  always_comb begin
    byte_val   = cmd_r.value;
    final_wait = WAIT_STEP;
    if (cmd_r.is_init) begin
      unique case (bidx_r)
        2'd0:    byte_val = cfg.func_set;
        2'd1:    byte_val = cfg.disp_ctl;
        2'd2:    byte_val = CMD_CLEAR;
        default: byte_val = cfg.entry_mode;
      endcase
      final_wait = (bidx_r == INIT_BYTE_LAST) ? WAIT_INIT_LAST : WAIT_INIT_BYTE;
    end
  end

  assign byte_done = !cmd_r.is_init || (bidx_r == INIT_BYTE_LAST);

  // Event generation
  always_comb begin
    ev = '0;
    unique case (state_r)
      ST_PRE:  ev = init_pre_event(step_r);
      ST_HEAD: ev = '{rs: held_sel_r, en: 1'b0, nib: held_nib_r, wait_us: WAIT_HEAD,
                      last: 1'b0};
      ST_BYTE: begin
        unique case (phase_r)
          PH_SETUP:   ev = '{rs: cmd_r.rs, en: 1'b0, nib: held_nib_r, wait_us: WAIT_STEP,
                             last: 1'b0};
          PH_HI_RISE: ev = '{rs: cmd_r.rs, en: 1'b1, nib: byte_val[7:4], wait_us: WAIT_STEP,
                             last: 1'b0};
          PH_HI_FALL: ev = '{rs: cmd_r.rs, en: 1'b0, nib: byte_val[7:4], wait_us: WAIT_STEP,
                             last: 1'b0};
          PH_LO_RISE: ev = '{rs: cmd_r.rs, en: 1'b1, nib: byte_val[3:0], wait_us: WAIT_STEP,
                             last: 1'b0};
          PH_LO_FALL: ev = '{rs: cmd_r.rs, en: 1'b0, nib: byte_val[3:0], wait_us: final_wait,
                             last: byte_done};
          default:    ev = '0;
        endcase
      end
      default: ev = '0;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    bidx_nxt  = bidx_r;
    cmd_nxt   = cmd_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = head_cmd;
          step_nxt  = '0;
          phase_nxt = PH_SETUP;
          bidx_nxt  = '0;
          state_nxt = head_cmd.is_init ? ST_PRE : ST_HEAD;
        end
      end
      ST_PRE: begin
        if (adv) begin
          if (step_r == INIT_PRE_LAST) begin
            state_nxt = ST_BYTE;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      ST_HEAD: begin
        if (adv) begin
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (adv) begin
          if (phase_r == PH_LO_FALL) begin
            phase_nxt = PH_SETUP;
            if (byte_done) begin
              state_nxt = ST_IDLE;
            end else begin
              bidx_nxt = bidx_r + 2'd1;
            end
          end else begin
            phase_nxt = byte_phase_t'(phase_r + 3'd1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register and pin levels left on the bus
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ev_nxt    = out_ev_r;
    held_nib_nxt  = held_nib_r;
    held_sel_nxt  = held_sel_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_ev_nxt    = ev;
      held_nib_nxt  = ev.nib;
      held_sel_nxt  = ev.rs;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      phase_r     <= PH_SETUP;
      bidx_r      <= '0;
      held_nib_r  <= '0;
      held_sel_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      bidx_r      <= bidx_nxt;
      held_nib_r  <= held_nib_nxt;
      held_sel_r  <= held_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    out_ev_r <= out_ev_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.reg_select   = out_ev_r.rs;
  assign out_ch.enable_level = out_ev_r.en;
  assign out_ch.bus_nibble   = out_ev_r.nib;
  assign out_ch.wait_us      = out_ev_r.wait_us;
  assign out_ch.last_event   = out_ev_r.last;

endmodule

### design/char_lcd_4bit_bus_sequencer.sv
// Top level: 4-bit character LCD bus sequencer, front end, command queue and back end.
// The first bus event of a command passes the queue and the back-end state register into the output register.
// Throughput: one bus event per cycle while the output is not stalled, plus a load step per command in the back end;
//   init gives 31 events, other commands 6 events.
// Inputs keep being accepted while the command queue has room, set by QUEUE_DEPTH.
// Reset: registers return to their defaults, queue empties, held RS and nibble clear to zero.
module char_lcd_4bit_bus_sequencer #(
  parameter int unsigned QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  clcd_in_if.sink    in_ch,
  clcd_cfg_if.sink   cfg_ch,
  clcd_out_if.source out_ch
);
  import clcd_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic q_push, q_full, q_pop, q_empty;

  clcd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd),
    .cfg    (cfg)
  );

  clcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  clcd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .head_cmd (head_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule

### tb/sv/char_lcd_4bit_bus_sequencer_checker.sv
// Checker for the LCD bus sequencer: predicts bus events per command beat and compares them.
module char_lcd_4bit_bus_sequencer_checker (
  input  logic clk,
  input  logic rst_n,
  clcd_in_if   in_mon,
  clcd_cfg_if  cfg_mon,
  clcd_out_if  out_mon,
  output int   errors,
  output int   pending
);
  import clcd_pkg::*;

  // Register file copy and the bus levels left on the pins
  cfg_t       regs;
  logic [3:0] pin_nibble;
  logic       pin_select;
  int         mismatches = 0;

  // Bus events still owed by the block, oldest first
  event_t bus_events_due[$];

  function automatic void push_bus_event(logic rs, logic en, logic [3:0] nib,
                                         logic [WAIT_W-1:0] hold);
    event_t ev;
    ev.rs      = rs;
    ev.en      = en;
    ev.nib     = nib;
    ev.wait_us = hold;
    ev.last    = 1'b0;
    bus_events_due.push_back(ev);
    pin_select = rs;
    pin_nibble = nib;
  endfunction

  // Setup, then upper nibble pulse, then lower nibble pulse
  function automatic void push_byte_write(logic rs, logic [7:0] b,
                                          logic [WAIT_W-1:0] tail_hold);
    push_bus_event(rs, 1'b0, pin_nibble, WAIT_STEP);
    push_bus_event(rs, 1'b1, b[7:4], WAIT_STEP);
    push_bus_event(rs, 1'b0, b[7:4], WAIT_STEP);
    push_bus_event(rs, 1'b1, b[3:0], WAIT_STEP);
    push_bus_event(rs, 1'b0, b[3:0], tail_hold);
  endfunction

  function automatic void push_nibble_pulse(logic [3:0] nib, logic [WAIT_W-1:0] tail_hold);
    push_bus_event(1'b0, 1'b0, nib, WAIT_STEP);
    push_bus_event(1'b0, 1'b1, nib, WAIT_STEP);
    push_bus_event(1'b0, 1'b0, nib, tail_hold);
  endfunction

  // Expand one command beat into its run of bus events
  function automatic void predict_command(logic [1:0] op, logic [7:0] b, logic [2:0] ln);
    event_t     tail;
    logic [6:0] addr;
    logic [7:0] value;
    logic       rs;
    if (op == OP_INIT) begin
      push_bus_event(1'b0, 1'b0, 4'h0, WAIT_POWER);
      push_nibble_pulse(NIB_WAKE, WAIT_5000);
      push_bus_event(1'b0, 1'b1, NIB_WAKE, WAIT_STEP);
      push_bus_event(1'b0, 1'b0, NIB_WAKE, WAIT_200);
      push_bus_event(1'b0, 1'b1, NIB_WAKE, WAIT_STEP);
      push_bus_event(1'b0, 1'b0, NIB_WAKE, WAIT_100);
      push_nibble_pulse(NIB_4BIT, WAIT_5000);
      push_byte_write(1'b0, regs.func_set, WAIT_INIT_BYTE);
      push_byte_write(1'b0, regs.disp_ctl, WAIT_INIT_BYTE);
      push_byte_write(1'b0, CMD_CLEAR, WAIT_INIT_BYTE);
      push_byte_write(1'b0, regs.entry_mode, WAIT_INIT_LAST);
    end else begin
      rs = (op == OP_DATA);
      value = b;
      if (op == OP_LINE) begin
        case (ln)
          LINE_NUM_2: addr = LINE2_ADDR;
          LINE_NUM_3: addr = regs.line3_addr;
          LINE_NUM_4: addr = regs.line4_addr;
          default:    addr = LINE1_ADDR;
        endcase
        value = CMD_DDRAM | {1'b0, addr};
      end
      // hold the current pins before the byte
      push_bus_event(pin_select, 1'b0, pin_nibble, WAIT_HEAD);
      push_byte_write(rs, value, WAIT_STEP);
    end
    tail = bus_events_due.pop_back();
    tail.last = 1'b1;
    bus_events_due.push_back(tail);
  endfunction

  // Per-edge monitor: check result beats, then track config and command beats
  always @(posedge clk) begin : monitor
    event_t got;
    event_t want;
    if (!rst_n) begin
      regs.func_set   = FUNC_SET_RST;
      regs.disp_ctl   = DISP_CTL_RST;
      regs.entry_mode = ENTRY_RST;
      regs.line3_addr = LINE3_RST;
      regs.line4_addr = LINE4_RST;
      pin_nibble = 4'h0;
      pin_select = 1'b0;
      bus_events_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.rs      = out_mon.reg_select;
        got.en      = out_mon.enable_level;
        got.nib     = out_mon.bus_nibble;
        got.wait_us = out_mon.wait_us;
        got.last    = out_mon.last_event;
        if (bus_events_due.size() == 0) begin
          $error("unexpected bus event beat: rs=%0d en=%0d nib=%0h wait=%0d last=%0d",
                 got.rs, got.en, got.nib, got.wait_us, got.last);
          mismatches++;
        end else begin
          want = bus_events_due.pop_front();
          if (got.rs !== want.rs) begin
            $error("reg_select: expected %0d, got %0d", want.rs, got.rs);
            mismatches++;
          end
          if (got.en !== want.en) begin
            $error("enable_level: expected %0d, got %0d", want.en, got.en);
            mismatches++;
          end
          if (got.nib !== want.nib) begin
            $error("bus_nibble: expected %0h, got %0h", want.nib, got.nib);
            mismatches++;
          end
          if (got.wait_us !== want.wait_us) begin
            $error("wait_us: expected %0d, got %0d", want.wait_us, got.wait_us);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last_event: expected %0d, got %0d", want.last, got.last);
            mismatches++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_index)
          REG_FUNC_SET: regs.func_set   = cfg_mon.data;
          REG_DISP_CTL: regs.disp_ctl   = cfg_mon.data;
          REG_ENTRY:    regs.entry_mode = cfg_mon.data;
          REG_LINE3:    regs.line3_addr = cfg_mon.data[6:0];
          REG_LINE4:    regs.line4_addr = cfg_mon.data[6:0];
          default:      ; // no register behind this index
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_command(in_mon.op, in_mon.data_byte, in_mon.line_number);
    end
    errors  <= mismatches;
    pending <= bus_events_due.size();
  end

endmodule

### tb/sv/char_lcd_4bit_bus_sequencer_tb.sv
// Testbench top for the LCD bus sequencer: clock, reset, command and config stimulus, verdict.
module char_lcd_4bit_bus_sequencer_tb;
  import clcd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 16;
  localparam int RAND_CMDS   = 35;
  // indexes with no register behind them
  localparam logic [2:0] NO_REG_LO = 3'd5;
  localparam logic [2:0] NO_REG_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  int   errors;
  int   pending;
  int   quiet = 0;
  int   burst_left = 1;
  bit   gaps_on = 1'b1;
  bit   hold_req = 1'b0;

  clcd_in_if  in_ch ();
  clcd_cfg_if cfg_ch ();
  clcd_out_if out_ch ();

  char_lcd_4bit_bus_sequencer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  char_lcd_4bit_bus_sequencer_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .cfg_mon (cfg_ch),
    .out_mon (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #4 clk = ~clk;

  // Watchdog: too long without any beat on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("char_lcd_4bit_bus_sequencer test failed");
      $finish;
    end
  end

  // Event sink: changing stall patterns, plus one long hold on request
  initial begin : event_sink
    int mode;
    int span;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      for (int k = 0; k < span; k++) begin
        if (hold_req) begin
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ((k % 4) != 1);
        endcase
        @(posedge clk);
      end
    end
  end

  // One command beat; bursts of random length separated by random gaps while gaps_on is set
  task automatic put_cmd(input op_t op, input logic [7:0] b, input logic [2:0] ln);
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.data_byte   <= b;
    in_ch.line_number <= ln;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 10);
      if (gaps_on) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // Stop sending and wait until every owed bus event has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write all five registers plus one index with no register
  task automatic set_config(input logic [7:0] fs, input logic [7:0] dc, input logic [7:0] em,
                            input logic [7:0] l3, input logic [7:0] l4,
                            input logic [2:0] spare_idx, input logic [7:0] spare_val);
    logic [2:0] idx [6];
    logic [7:0] val [6];
    idx = '{REG_FUNC_SET, REG_DISP_CTL, REG_ENTRY, REG_LINE3, REG_LINE4, spare_idx};
    val = '{fs, dc, em, l3, l4, spare_val};
    for (int i = 0; i < 6; i++) begin
      cfg_ch.valid     <= 1'b1;
      cfg_ch.reg_index <= idx[i];
      cfg_ch.data      <= val[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return OP_INIT;
    if (r < 38) return OP_CMD;
    if (r < 69) return OP_DATA;
    return OP_LINE;
  endfunction

  task automatic put_random(input int count);
    for (int i = 0; i < count; i++)
      put_cmd(pick_op(), 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
  endtask

  task automatic line_sweep();
    for (int ln = 0; ln < 8; ln++)
      put_cmd(OP_LINE, 8'($urandom_range(0, 255)), 3'(ln));
  endtask

  // Main stimulus
  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_INIT;
    in_ch.data_byte    <= 8'h00;
    in_ch.line_number  <= 3'd0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.reg_index   <= REG_FUNC_SET;
    cfg_ch.data        <= 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: command before init, byte extremes, every line, init back to back
    put_cmd(OP_CMD, 8'h00, 3'd7);
    put_cmd(OP_INIT, 8'hFF, 3'd0);
    put_cmd(OP_DATA, 8'hFF, 3'd5);
    put_cmd(OP_DATA, 8'h00, 3'd2);
    put_cmd(OP_CMD, 8'hA5, 3'd3);
    put_cmd(OP_DATA, 8'h5A, 3'd4);
    line_sweep();
    put_cmd(OP_INIT, 8'h00, 3'd7);
    put_cmd(OP_INIT, 8'h0F, 3'd1);
    put_cmd(OP_CMD, 8'h0F, 3'd6);
    put_cmd(OP_DATA, 8'hF0, 3'd1);
    drain();

    // all registers at zero; long sink hold while commands keep coming
    set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, NO_REG_LO, 8'hFF);
    put_cmd(OP_INIT, 8'h00, 3'd0);
    line_sweep();
    hold_req = 1'b1;
    gaps_on = 1'b0;
    put_random(12);
    gaps_on = 1'b1;
    put_random(RAND_CMDS);
    drain();

    // all registers at their maximum
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, NO_REG_HI, 8'h00);
    put_cmd(OP_INIT, 8'hFF, 3'd7);
    line_sweep();
    put_random(RAND_CMDS);
    drain();

    // random registers, sender without gaps
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)),
               3'($urandom_range(NO_REG_HI, NO_REG_LO)), 8'($urandom_range(0, 255)));
    gaps_on = 1'b0;
    put_random(RAND_CMDS);
    gaps_on = 1'b1;
    drain();

    // back to the reset defaults
    set_config(FUNC_SET_RST, DISP_CTL_RST, ENTRY_RST, {1'b0, LINE3_RST}, {1'b0, LINE4_RST},
               NO_REG_LO, 8'hA5);
    put_random(RAND_CMDS);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("char_lcd_4bit_bus_sequencer test passed");
    else
      $display("char_lcd_4bit_bus_sequencer test failed");
    $finish;
  end

endmodule

### files.f
design/clcd_pkg.sv
design/clcd_in_if.sv
design/clcd_out_if.sv
design/clcd_cfg_if.sv
design/clcd_front.sv
design/clcd_queue.sv
design/clcd_back.sv
design/char_lcd_4bit_bus_sequencer.sv
tb/sv/char_lcd_4bit_bus_sequencer_checker.sv
tb/sv/char_lcd_4bit_bus_sequencer_tb.sv
